[src/mxll_pkg.sv]
// ----------------------------------------------------------------------------
// mxll_pkg
// Shared types and constants for the mesh XY link load accounting block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mxll_pkg;

    localparam int DIRS = 4;

    // Function codes carried in tuser.
    localparam logic [1:0] FUNC_UNI   = 2'd0;
    localparam logic [1:0] FUNC_MC    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Link directions.
    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_YM = 2'd1;
    localparam logic [1:0] DIR_XM = 2'd2;
    localparam logic [1:0] DIR_YP = 2'd3;

    // Route segment slots walked for every unicast and multicast item.
    localparam logic [2:0] SEG_PRE      = 3'd0;
    localparam logic [2:0] SEG_OLD_DN   = 3'd1;
    localparam logic [2:0] SEG_OLD_UP   = 3'd2;
    localparam logic [2:0] SEG_NEW_DN   = 3'd3;
    localparam logic [2:0] SEG_NEW_UP   = 3'd4;
    localparam logic [2:0] SEG_TRUNK    = 3'd5;

    typedef struct packed {
        logic       latch;
        logic       clr_start;
        logic       clr_step;
        logic       seg_load;
        logic [2:0] seg;
        logic       rd;
        logic       wr;
        logic       mc_upd;
        logic       mc_fin;
        logic       mul;
        logic       acc;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       last;
        logic       seg_zero;
        logic       walk_last;
        logic       clr_done;
        logic       out_busy;
    } status_t;

endpackage

[src/mesh_xy_link_load_accounting_top.sv]
// ----------------------------------------------------------------------------
// mesh_xy_link_load_accounting_top
// XY-routed mesh traffic accounting with per-link load counters.
//
// Channel | Direction | Width | Contents
// s_axis  | in        | 48+2+1| tdata route and size, tuser function, tlast
// m_axis  | out       | 152   | tdata hop product, running total, peak load
// cfg     | in        | 1     | link accounting enable
//
// From acceptance until the input is ready again, an item passes through the
// accept cycle and six segment loads, and each link is a read then a write of
// the single-port link load memory. A multicast item adds its state update; a
// result adds the multiply and output steps, and a multicast one the final step.
// After reset and after a clear, a sweep zeroes every entry of the memory; no
// item is accepted during it, configuration writes are.
// A new item is accepted while a result still waits on m_axis; the next result
// then holds the sequencer until the waiting one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_xy_link_load_accounting_top
    import mxll_pkg::*;
#(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // src_x, src_y, dst_x, dst_y, size
    input  logic [1:0]   s_axis_tuser,  // func
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,  // hops_added, running hop total, max_link_load
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    cmd_t    cmd;
    status_t status;

    mxll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mxll_dp #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_func   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> cmd.wr)
        else $error("link read not followed by write");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd, cmd.wr, cmd.clr_step, cmd.acc, cmd.mul}))
        else $error("conflicting datapath commands");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_CLEAR) |=> !s_axis_tready)
        else $error("item accepted during clearing sweep");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr || cmd.clr_step) |-> !s_axis_tready)
        else $error("input ready while datapath busy");

endmodule

[src/mxll_ctrl.sv]
// ----------------------------------------------------------------------------
// mxll_ctrl
// Sequencer: clearing sweep, route segment walk, multiply and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxll_ctrl
    import mxll_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_func,
    output logic       in_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_WR    = 9'b000010000,
        S_MCUPD = 9'b000100000,
        S_MCFIN = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_ACC   = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] seg_reg, seg_next;
    state_t     adv_state;
    logic [2:0] adv_seg;

    // Where to go once the current segment is finished.
    always_comb
    begin
        adv_state = S_LOAD;
        adv_seg   = seg_reg + 3'd1;
        if (seg_reg == SEG_OLD_UP && status.func == FUNC_MC)
        begin
            adv_state = S_MCUPD;
        end
        else if (seg_reg == SEG_TRUNK)
        begin
            adv_seg = SEG_PRE;
            if (status.func == FUNC_UNI)
            begin
                adv_state = S_MUL;
            end
            else if (status.last)
            begin
                adv_state = S_MCFIN;
            end
            else
            begin
                adv_state = S_IDLE;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        cmd        = '0;
        cmd.seg    = seg_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    seg_next  = SEG_PRE;
                    if (in_func == FUNC_UNI || in_func == FUNC_MC)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (in_func == FUNC_CLEAR)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_CLEAR;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.seg_load = 1'b1;
                if (status.seg_zero)
                begin
                    state_next = adv_state;
                    seg_next   = adv_seg;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (status.walk_last)
                begin
                    state_next = adv_state;
                    seg_next   = adv_seg;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_MCUPD:
            begin
                cmd.mc_upd = 1'b1;
                state_next = S_LOAD;
            end
            S_MCFIN:
            begin
                cmd.mc_fin = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!status.out_busy)
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            seg_reg   <= SEG_PRE;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

endmodule

[src/mxll_dp.sv]
// ----------------------------------------------------------------------------
// mxll_dp
// Datapath: item registers, multicast state, link load memory, route walker,
// hop product and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxll_dp
    import mxll_pkg::*;
#(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output status_t      status,
    input  logic [47:0]  in_data,
    input  logic [1:0]   in_func,
    input  logic         in_last,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [151:0] out_data
);

    localparam int DEPTH = GRID_X * GRID_Y * DIRS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [3:0] absdiff(input logic [3:0] a, input logic [3:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [3:0] span(input logic [3:0] a, input logic [3:0] hi,
                                        input logic [3:0] lo);
        logic [3:0] h;
        logic [3:0] l;
        h = (a > hi) ? a : hi;
        l = (a < lo) ? a : lo;
        return h - l;
    endfunction

    function automatic logic [9:0] sat10(input logic [9:0] a, input logic [3:0] b);
        logic [10:0] s;
        s = {1'b0, a} + {7'd0, b};
        return s[10] ? 10'h3FF : s[9:0];
    endfunction

    logic [1:0]  func_reg;
    logic        last_reg;
    logic [3:0]  sx_reg, sy_reg, dx_reg, dy_reg;
    logic [31:0] size_reg;
    logic        en_reg;

    logic        mc_active_reg;
    logic [3:0]  mc_first_x_reg, mc_col_x_reg, mc_min_y_reg, mc_last_y_reg;
    logic [9:0]  mc_hops_reg;

    logic [55:0] total_reg;
    logic [47:0] peak_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [3:0]  wx_reg, wy_reg, wcnt_reg;
    logic [1:0]  wdir_reg;
    logic        ingrid_reg;
    logic [47:0] rdata_reg;

    logic [9:0]  hopv_reg;
    logic [41:0] prod_reg;
    logic        out_valid_reg;
    logic [47:0] out_hops_reg, out_peak_reg;
    logic [55:0] out_total_reg;

    logic [47:0] mem [DEPTH];

    logic [3:0]  seg_x, seg_y, seg_cnt;
    logic [1:0]  seg_dir;
    logic        mc_old, mc_fin;
    logic        ingrid;
    logic [AW-1:0] link_addr;
    logic [48:0] link_sum;
    logic [47:0] link_new;
    logic [56:0] total_sum;
    logic [4:0]  uni_hops;

    assign mc_old = (func_reg == FUNC_MC) && mc_active_reg && (dx_reg != mc_col_x_reg);
    assign mc_fin = (func_reg == FUNC_MC) && last_reg;

    // Start point, direction and length of the requested route segment.
    always_comb
    begin
        seg_x   = sx_reg;
        seg_y   = sy_reg;
        seg_dir = DIR_XP;
        seg_cnt = 4'd0;
        case (cmd.seg)
            SEG_PRE:
            begin
                seg_dir = (dx_reg > sx_reg) ? DIR_XP : DIR_XM;
                if (func_reg == FUNC_UNI)
                begin
                    seg_cnt = absdiff(dx_reg, sx_reg);
                end
                else if (func_reg == FUNC_MC && !mc_active_reg && sx_reg > dx_reg)
                begin
                    seg_cnt = sx_reg - dx_reg;
                end
            end
            SEG_OLD_DN, SEG_NEW_DN:
            begin
                seg_x   = mc_col_x_reg;
                seg_dir = DIR_YM;
                if ((cmd.seg == SEG_OLD_DN) ? mc_old : mc_fin)
                begin
                    seg_cnt = (sy_reg > mc_min_y_reg) ? sy_reg - mc_min_y_reg : 4'd0;
                end
                if (cmd.seg == SEG_NEW_DN && func_reg == FUNC_UNI)
                begin
                    seg_x   = dx_reg;
                    seg_dir = (dy_reg > sy_reg) ? DIR_YP : DIR_YM;
                    seg_cnt = absdiff(dy_reg, sy_reg);
                end
            end
            SEG_OLD_UP, SEG_NEW_UP:
            begin
                seg_x   = mc_col_x_reg;
                seg_dir = DIR_YP;
                if ((cmd.seg == SEG_OLD_UP) ? mc_old : mc_fin)
                begin
                    seg_cnt = (mc_last_y_reg > sy_reg) ? mc_last_y_reg - sy_reg : 4'd0;
                end
            end
            SEG_TRUNK:
            begin
                if (mc_fin && dx_reg > sx_reg)
                begin
                    seg_cnt = dx_reg - sx_reg;
                end
            end
            default:
            begin
                seg_cnt = 4'd0;
            end
        endcase
        if (!en_reg)
        begin
            seg_cnt = 4'd0;
        end
    end

    assign ingrid    = (32'(wx_reg) < GRID_X) && (32'(wy_reg) < GRID_Y);
    assign link_addr = AW'((32'(wx_reg) * GRID_Y + 32'(wy_reg)) * DIRS + 32'(wdir_reg));
    assign link_sum  = {1'b0, rdata_reg} + {17'd0, size_reg};
    assign link_new  = link_sum[48] ? {48{1'b1}} : link_sum[47:0];
    assign total_sum = {1'b0, total_reg} + {15'd0, prod_reg};
    assign uni_hops  = {1'b0, absdiff(dx_reg, sx_reg)} + {1'b0, absdiff(dy_reg, sy_reg)};

    // Link load memory: one write port shared by the clearing sweep and the walk.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wr && ingrid_reg)
        begin
            mem[link_addr] <= link_new;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[link_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= in_func;
            last_reg <= in_last;
            sx_reg   <= in_data[3:0];
            sy_reg   <= in_data[7:4];
            dx_reg   <= in_data[11:8];
            dy_reg   <= in_data[15:12];
            size_reg <= in_data[47:16];
        end
        if (cmd.seg_load)
        begin
            wx_reg   <= seg_x;
            wy_reg   <= seg_y;
            wdir_reg <= seg_dir;
            wcnt_reg <= seg_cnt;
        end
        if (cmd.rd)
        begin
            ingrid_reg <= ingrid;
        end
        if (cmd.wr)
        begin
            wcnt_reg <= wcnt_reg - 4'd1;
            case (wdir_reg)
                DIR_XP:  wx_reg <= wx_reg + 4'd1;
                DIR_XM:  wx_reg <= wx_reg - 4'd1;
                DIR_YP:  wy_reg <= wy_reg + 4'd1;
                DIR_YM:  wy_reg <= wy_reg - 4'd1;
                default: wx_reg <= wx_reg;
            endcase
        end
        if (cmd.mc_fin)
        begin
            hopv_reg <= sat10(sat10(mc_hops_reg, span(sy_reg, mc_last_y_reg, mc_min_y_reg)),
                              span(sx_reg, dx_reg, mc_first_x_reg));
        end
        if (cmd.mul)
        begin
            prod_reg <= ((func_reg == FUNC_UNI) ? {5'd0, uni_hops} : hopv_reg) * size_reg;
        end
        if (cmd.acc)
        begin
            out_hops_reg  <= {6'd0, prod_reg};
            out_total_reg <= total_sum[56] ? {56{1'b1}} : total_sum[55:0];
            out_peak_reg  <= peak_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg         <= 1'b1;
            mc_active_reg  <= 1'b0;
            mc_first_x_reg <= '0;
            mc_col_x_reg   <= '0;
            mc_min_y_reg   <= '0;
            mc_last_y_reg  <= '0;
            mc_hops_reg    <= '0;
            total_reg      <= '0;
            peak_reg       <= '0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                en_reg <= cfg_data;
            end
            if (cmd.clr_start)
            begin
                mc_active_reg  <= 1'b0;
                mc_first_x_reg <= '0;
                mc_col_x_reg   <= '0;
                mc_min_y_reg   <= '0;
                mc_last_y_reg  <= '0;
                mc_hops_reg    <= '0;
                total_reg      <= '0;
                peak_reg       <= '0;
                clr_cnt_reg    <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.wr && ingrid_reg && link_new > peak_reg)
            begin
                peak_reg <= link_new;
            end
            if (cmd.mc_upd)
            begin
                if (!mc_active_reg)
                begin
                    mc_active_reg  <= 1'b1;
                    mc_first_x_reg <= dx_reg;
                    mc_col_x_reg   <= dx_reg;
                    mc_min_y_reg   <= dy_reg;
                    mc_last_y_reg  <= dy_reg;
                    mc_hops_reg    <= '0;
                end
                else if (dx_reg != mc_col_x_reg)
                begin
                    mc_hops_reg   <= sat10(mc_hops_reg,
                                           span(sy_reg, mc_last_y_reg, mc_min_y_reg));
                    mc_col_x_reg  <= dx_reg;
                    mc_min_y_reg  <= dy_reg;
                    mc_last_y_reg <= dy_reg;
                end
                else
                begin
                    mc_last_y_reg <= dy_reg;
                end
            end
            if (cmd.mc_fin)
            begin
                mc_active_reg <= 1'b0;
                mc_hops_reg   <= '0;
            end
            if (cmd.acc)
            begin
                total_reg     <= total_sum[56] ? {56{1'b1}} : total_sum[55:0];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = {out_peak_reg, out_total_reg, out_hops_reg};

    assign status.func      = func_reg;
    assign status.last      = last_reg;
    assign status.seg_zero  = (seg_cnt == 4'd0);
    assign status.walk_last = (wcnt_reg == 4'd1);
    assign status.clr_done  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

[bench/tb_mesh_xy_link_load_accounting_top.sv]
// ----------------------------------------------------------------------------
// tb_mesh_xy_link_load_accounting_top
// Self-checking bench for the mesh XY link load accounting block. Route
// items, multicast groups and clears are streamed in with random gaps. A
// behavioral copy of the accounting predicts every result, and the results
// are checked in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mesh_xy_link_load_accounting_top;
    import mxll_pkg::*;

    localparam int GX = 16;
    localparam int GY = 16;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [55:0] SAT56 = 56'hFF_FFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    // Packed from the top bit down, so hops_added sits in the lowest bits.
    typedef struct packed {
        logic [47:0] max_link_load;
        logic [55:0] run_total;
        logic [47:0] hops_added;
    } load_report_t;

    class load_scoreboard;
        logic [47:0] link_load [GX*GY*DIRS];
        logic [55:0] hop_total;
        logic [47:0] peak_load;
        logic [3:0]  first_x, col_x, col_min_y, col_last_y;
        logic [9:0]  mc_hops;
        bit          mc_active;
        bit          acct_en;
        load_report_t pending [$];
        int errors = 0;

        function void reset_all();
            foreach (link_load[i]) link_load[i] = '0;
            hop_total = '0;
            peak_load = '0;
            first_x = '0;
            col_x = '0;
            col_min_y = '0;
            col_last_y = '0;
            mc_hops = '0;
            mc_active = 0;
        endfunction

        function void add_link(int x, int y, logic [1:0] dir, logic [31:0] size);
            int idx;
            logic [48:0] v;
            if (x >= GX || y >= GY)
                return;
            idx = (x * GY + y) * DIRS + dir;
            v = {1'b0, link_load[idx]} + size;
            if (v > SAT48)
                v = SAT48;
            link_load[idx] = v[47:0];
            if (v[47:0] > peak_load)
                peak_load = v[47:0];
        endfunction

        function void add_mc_hops(int h);
            int v;
            v = mc_hops + h;
            mc_hops = (v > 1023) ? 10'd1023 : v[9:0];
        endfunction

        function void close_col(int sy, logic [31:0] size);
            int y;
            int hi;
            int lo;
            if (acct_en)
            begin
                for (y = sy; y > col_min_y; y--) add_link(col_x, y, DIR_YM, size);
                for (y = sy; y < col_last_y; y++) add_link(col_x, y, DIR_YP, size);
            end
            hi = (sy > col_last_y) ? sy : col_last_y;
            lo = (sy < col_min_y) ? sy : col_min_y;
            add_mc_hops(hi - lo);
        endfunction

        function void push_result(longint unsigned hops, logic [31:0] size);
            load_report_t r;
            logic [80:0] prod;
            logic [56:0] t;
            prod = hops * size;
            t = {1'b0, hop_total} + prod;
            if (t > SAT56)
                t = SAT56;
            hop_total = t[55:0];
            r.hops_added = prod[47:0];
            r.run_total = hop_total;
            r.max_link_load = peak_load;
            pending.insert(pending.size(), r);
        endfunction

        function void note_input(logic [1:0] func, int sx, int sy, int dx, int dy,
                                 logic [31:0] size, bit last);
            int x;
            int y;
            int hi;
            int lo;
            if (func == FUNC_UNI)
            begin
                if (acct_en)
                begin
                    if (dx > sx)
                        for (x = sx; x < dx; x++) add_link(x, sy, DIR_XP, size);
                    else
                        for (x = sx; x > dx; x--) add_link(x, sy, DIR_XM, size);
                    if (dy > sy)
                        for (y = sy; y < dy; y++) add_link(dx, y, DIR_YP, size);
                    else
                        for (y = sy; y > dy; y--) add_link(dx, y, DIR_YM, size);
                end
                push_result(((dx > sx) ? dx - sx : sx - dx) +
                            ((dy > sy) ? dy - sy : sy - dy), size);
                return;
            end
            if (func == FUNC_CLEAR)
            begin
                reset_all();
                return;
            end
            if (func != FUNC_MC)
                return;
            if (!mc_active)
            begin
                mc_active = 1;
                first_x = dx;
                col_x = dx;
                col_min_y = dy;
                col_last_y = dy;
                mc_hops = '0;
                if (acct_en)
                    for (x = sx; x > dx; x--) add_link(x, sy, DIR_XM, size);
            end
            else if (dx != col_x)
            begin
                close_col(sy, size);
                col_x = dx;
                col_min_y = dy;
                col_last_y = dy;
            end
            else
                col_last_y = dy;
            if (!last)
                return;
            close_col(sy, size);
            if (acct_en)
                for (x = sx; x < dx; x++) add_link(x, sy, DIR_XP, size);
            hi = (sx > dx) ? sx : dx;
            lo = (sx < first_x) ? sx : first_x;
            add_mc_hops(hi - lo);
            mc_active = 0;
            push_result(mc_hops, size);
            mc_hops = '0;
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("error: %s got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(load_report_t got);
            load_report_t w;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing expected", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.hops_added != w.hops_added)
                report_mismatch("hops_added", got.hops_added, w.hops_added);
            if (got.run_total != w.run_total)
                report_mismatch("running total", got.run_total, w.run_total);
            if (got.max_link_load != w.max_link_load)
                report_mismatch("max_link_load", got.max_link_load, w.max_link_load);
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;

    load_scoreboard sb;
    longint cycles;
    int  hold_cycles;
    bit  sink_burst;

    mesh_xy_link_load_accounting_top #(.GRID_X(GX), .GRID_Y(GY)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("mesh_xy_link_load_accounting_top: mismatch");
                $finish;
            end
        end
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Result sink: random stalls, plus a long hold-off when requested.
    initial
    begin
        int gap;
        m_axis_tready = 0;
        gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 0;
            end
            else if (sink_burst)
                m_axis_tready <= 1;
            else if (gap > 0)
            begin
                gap--;
                m_axis_tready <= 0;
            end
            else
            begin
                m_axis_tready <= 1;
                if ($urandom_range(0, 3) == 0)
                    gap = rand_gap();
            end
        end
    end

    // tvalid stays high after a transaction; it drops when a gap follows or on a drain.
    task automatic send_item(logic [1:0] func, int sx, int sy, int dx, int dy,
                             logic [31:0] size, bit last, bit no_gap);
        int g;
        g = no_gap ? 0 : rand_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {size, dy[3:0], dx[3:0], sy[3:0], sx[3:0]};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(func, sx, sy, dx, dy, size, last);
    endtask

    // Waits until every result has come and the block is idle again.
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0 || !s_axis_tready) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cfg(bit v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.acct_en = v;
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 0;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Multicast group, mostly sorted; sometimes unsorted or with mixed sources.
    task automatic send_multicast(bit no_gap);
        int n;
        int sx;
        int sy;
        int x;
        int y;
        bit messy;
        logic [31:0] sz;
        n = $urandom_range(1, 6);
        sx = $urandom_range(0, 15);
        sy = $urandom_range(0, 15);
        sz = rand_size();
        messy = ($urandom_range(0, 7) == 0);
        x = $urandom_range(0, 8);
        y = $urandom_range(0, 15);
        for (int i = 0; i < n; i++)
        begin
            if (messy)
            begin
                x = $urandom_range(0, 15);
                y = $urandom_range(0, 15);
                sx = $urandom_range(0, 15);
                sz = rand_size();
            end
            else if (i > 0)
            begin
                if ($urandom_range(0, 1) && x < 15)
                begin
                    x = $urandom_range(x + 1, 15);
                    y = $urandom_range(0, 15);
                end
                else if (y < 15)
                    y = $urandom_range(y, 15);
            end
            send_item(FUNC_MC, sx, sy, x, y, sz, i == n - 1, no_gap);
        end
    endtask

    task automatic random_item(bit no_gap);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send_item(FUNC_UNI, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15), rand_size(),
                      $urandom_range(0, 1), no_gap);
        else if (r < 95)
            send_multicast(no_gap);
        else if (r < 97)
            send_item(FUNC_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                      $urandom_range(0, 1), no_gap);
        else
            send_item(2'd3, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                      $urandom_range(0, 1), no_gap);
    endtask

    initial
    begin
        sb = new();
        sb.reset_all();
        sb.acct_en = 1;
        hold_cycles = 0;
        sink_burst = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_UNI;
        s_axis_tlast = 0;
        cfg_valid = 0;
        cfg_data = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: corners, zero and full size, repeated full-size load on one link.
        send_item(FUNC_UNI, 0, 0, 15, 15, 32'hFFFF_FFFF, 0, 0);
        send_item(FUNC_UNI, 15, 15, 0, 0, 32'hFFFF_FFFF, 1, 0);
        send_item(FUNC_UNI, 5, 5, 5, 5, 32'hFFFF_FFFF, 0, 0);
        send_item(FUNC_UNI, 3, 9, 3, 2, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            send_item(FUNC_UNI, 0, 0, 1, 0, 32'hFFFF_FFFF, 0, 0);
        // Sorted multicast, then one with a single item.
        send_item(FUNC_MC, 8, 7, 2, 1, 100, 0, 0);
        send_item(FUNC_MC, 8, 7, 2, 12, 100, 0, 0);
        send_item(FUNC_MC, 8, 7, 11, 4, 100, 1, 0);
        send_item(FUNC_MC, 0, 0, 15, 15, 32'hFFFF_FFFF, 1, 0);
        // Unsorted with revisited column and mixed fields.
        send_item(FUNC_MC, 4, 4, 9, 3, 7, 0, 0);
        send_item(FUNC_MC, 12, 6, 2, 14, 9, 0, 0);
        send_item(FUNC_MC, 1, 2, 9, 0, 11, 1, 0);
        // Unicast during a multicast, unused code during one.
        send_item(FUNC_MC, 6, 6, 3, 3, 5, 0, 0);
        send_item(FUNC_UNI, 1, 1, 14, 2, 3, 0, 0);
        send_item(2'd3, 15, 15, 15, 15, 32'hFFFF_FFFF, 1, 0);
        send_item(FUNC_MC, 6, 6, 13, 10, 5, 1, 0);
        // Clear during a multicast, then a unicast item.
        send_item(FUNC_MC, 2, 2, 4, 4, 5, 0, 0);
        send_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 1, 0);
        send_item(FUNC_UNI, 2, 2, 4, 4, 5, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_cfg(phase[0]);
            for (int i = 0; i < 200; i++)
            begin
                if (i == 25)
                    hold_cycles = 3000;
                sink_burst = (i >= 150 && i < 170);
                if (i == 100)
                    drain();
                random_item(i >= 150 && i < 170);
            end
        end
        write_cfg(1);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("mesh_xy_link_load_accounting_top: match");
        else
            $display("mesh_xy_link_load_accounting_top: mismatch");
        $finish;
    end

endmodule
